// ===== hw/rtl/deq_pkg.sv =====
// Shared types, constants and helpers for the double-ended queue unit.
// Depends on nothing; deq_front, deq_back, the top level and deq_checker import it.
`timescale 1ns / 1ps

package deq_pkg;

  // Ring store geometry
  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Request function codes
  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_DISPLAY    = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DISPLAY,
    OP_INVALID
  } deq_op_t;

  // Classified request handed from front to back
  typedef struct packed {
    deq_op_t                  op;
    logic signed [DATA_W-1:0] value;
  } deq_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_DISP
  } deq_state_t;

  // (base + off) modulo DEPTH, both operands below DEPTH
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/deq_front.sv =====
// Front end: accepts requests, decodes func into an operation and queues them.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_func,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                            cmd_valid,
  output deq_pkg::deq_cmd_t               cmd,
  input  logic                            cmd_take
);
  import deq_pkg::*;

  deq_cmd_t            slot_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                push;
  logic                pop;
  deq_cmd_t            dec_cmd;

  function automatic logic [CQ_PTR_W-1:0] cq_inc(input logic [CQ_PTR_W-1:0] p);
    return (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + CQ_PTR_W'(1);
  endfunction

  // Decode
  always_comb begin
    dec_cmd.value = in_value;
    case (in_func)
      FN_PUSH_FRONT: dec_cmd.op = OP_PUSH_FRONT;
      FN_PUSH_BACK:  dec_cmd.op = OP_PUSH_BACK;
      FN_POP_FRONT:  dec_cmd.op = OP_POP_FRONT;
      FN_POP_BACK:   dec_cmd.op = OP_POP_BACK;
      FN_DISPLAY:    dec_cmd.op = OP_DISPLAY;
      default:       dec_cmd.op = OP_INVALID;
    endcase
  end

  assign in_stall  = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = slot_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_take && cmd_valid;

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = push ? cq_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? cq_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

// ===== hw/rtl/deq_back.sv =====
// Back end: executes queued operations on the ring store and drives results.
// Depends on deq_pkg and deq_ram.
`timescale 1ns / 1ps

module deq_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  deq_pkg::deq_cmd_t                 cmd,
  output logic                              cmd_take,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [deq_pkg::DATA_W-1:0] out_data_out,
  output logic                              out_last
);
  import deq_pkg::*;

  deq_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [PTR_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r;

  logic              out_free;
  logic              is_full;
  logic              is_empty;
  logic [CNT_W-1:0]  occ_m1;
  logic              disp_last;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              load;
  logic [1:0]        ld_status;
  logic [DATA_W-1:0] ld_data;
  logic              ld_last;

  deq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign is_full   = (occ_r == CNT_W'(DEPTH));
  assign is_empty  = (occ_r == '0);
  assign occ_m1    = occ_r - CNT_W'(1);
  assign disp_last = (CNT_W'(idx_r) == occ_m1);

  // Sequencer: next state, store access and result load
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    cmd_take  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    wr_data   = cmd.value;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    load      = 1'b0;
    ld_status = ST_OK;
    ld_data   = '0;
    ld_last   = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          case (cmd.op)
            OP_PUSH_FRONT: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = ST_FULL;
              end else begin
                front_nxt = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
                wr_en     = 1'b1;
                wr_addr   = front_nxt;
                occ_nxt   = occ_r + CNT_W'(1);
                ld_data   = cmd.value;
              end
            end
            OP_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring_add(front_r, occ_r[PTR_W-1:0]);
                occ_nxt = occ_r + CNT_W'(1);
                ld_data = cmd.value;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                front_nxt = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + PTR_W'(1);
                occ_nxt   = occ_m1;
                state_nxt = BK_POP;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ring_add(front_r, occ_m1[PTR_W-1:0]);
                occ_nxt   = occ_m1;
                state_nxt = BK_POP;
              end
            end
            OP_DISPLAY: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = front_r;
                idx_nxt   = '0;
                state_nxt = BK_DISP;
              end
            end
            default: begin
              load      = 1'b1;
              ld_status = ST_INVALID;
            end
          endcase
        end
      end
      BK_POP: begin
        // read data arrives in the cycle after the address
        if (out_free) begin
          load      = 1'b1;
          ld_data   = rd_data;
          state_nxt = BK_IDLE;
        end
      end
      BK_DISP: begin
        // one entry per cycle while the output is free; next read overlaps the current load
        if (out_free) begin
          load    = 1'b1;
          ld_data = rd_data;
          ld_last = disp_last;
          if (disp_last) begin
            state_nxt = BK_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ring_add(front_r, idx_r + PTR_W'(1));
            idx_nxt = idx_r + PTR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// Bounded double-ended queue of signed 32-bit values in a 16-entry ring RAM.
// Requests enter a two-slot command queue, and the back unit executes one
// request at a time: a push, an error case or an invalid func loads its result
// straight from idle; a successful pop first reads the ring RAM and then loads
// the registered read data; display reads the entries in turn, one read and
// one result per cycle after the first read while the output is not stalled.
// Results leave through an output register, so the front keeps accepting while
// a result waits. Entries need no clearing after reset; the unit is ready out of reset.
// Depends on deq_pkg, deq_front, deq_back and deq_ram.
`timescale 1ns / 1ps

module double_ended_queue_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_func,
  input  logic signed [deq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [deq_pkg::DATA_W-1:0] out_data_out,
  output logic                              out_last
);
  import deq_pkg::*;

  logic     cmd_valid;
  deq_cmd_t cmd;
  logic     cmd_take;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  deq_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

endmodule

// ===== hw/rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue unit, bound to its top level.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [2:0]                        in_func,
  input logic signed [deq_pkg::DATA_W-1:0] in_value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        out_status,
  input logic signed [deq_pkg::DATA_W-1:0] out_data_out,
  input logic                              out_last
);
  import deq_pkg::*;

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled request holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_value))
    else $error("stalled request changed");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_data_out)
                               && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // Error results close their request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error result without last");

  // Error results carry zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_status != ST_OK) |-> (out_data_out == '0))
    else $error("error result with nonzero data");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_func      (in_func),
  .in_value     (in_value),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_data_out (out_data_out),
  .out_last     (out_last)
);
